@@ src/hdtm_pkg.sv @@
// Shared types and constants for the HPACK dynamic table manager.
`timescale 1ns / 1ps

package hdtm_pkg;

  // Per-entry overhead added to name and value lengths (RFC 7541 section 4.1)
  localparam int ENTRY_OVERHEAD = 32;
  // Width of name_len + value_len + overhead
  localparam int ESIZE_W = 18;
  // Width of the size limit register
  localparam int LIMIT_W = 13;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_RESIZE = 2'd2
  } hdtm_op_e;

  typedef enum logic [2:0] {
    STAT_STATIC_HIT  = 3'd0,
    STAT_DYNAMIC_HIT = 3'd1,
    STAT_INVALID     = 3'd2,
    STAT_INSERTED    = 3'd3,
    STAT_TOO_LARGE   = 3'd4,
    STAT_RESIZED     = 3'd5,
    STAT_OVER_LIMIT  = 3'd6
  } hdtm_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EVICT,
    S_FINISH
  } hdtm_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] index;
    logic [15:0] name_len;
    logic [15:0] value_len;
    logic [15:0] req_size;
  } hdtm_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] static_pos;
    logic [6:0] entry_slot;
    logic [7:0] evicted;
    logic [7:0] entry_count;
    logic [12:0] table_bytes;
  } hdtm_out_t;

endpackage

@@ src/hpack_dynamic_table_manager.sv @@
// HPACK dynamic table size bookkeeping: ring of entry sizes, eviction, index lookup.
`timescale 1ns / 1ps

// Usage
//   in_valid/in_ready/in_data carry one operation: lookup of a combined
//   1-based index, insert of an entry (name_len + value_len + 32 bytes) or
//   resize of the table maximum. Op code 3 is dropped without a result.
//   out_valid/out_ready/out_data carry one result per operation.
//   cfg_valid/cfg_ready/cfg_data write size_limit, the protocol maximum;
//   cfg_ready is always high. Write it only while the block is idle.
// Sequencing
//   The entry sizes sit in a single-port-read ring memory with a registered
//   read port. Each evicted entry takes a pass through S_CHECK, which reads
//   the oldest size, and S_EVICT, which subtracts it from the byte total.
//   The result is registered in S_FINISH, after S_CHECK and the S_EVICT
//   passes; in_ready is high only in S_IDLE, so a new item is taken only
//   after the block returns there and items never overlap.
//   A finished result waits in the output register; the next item is taken
//   meanwhile and its result is held back until out_ready frees the register.
// Reset
//   rst (synchronous) empties the table, sets the maximum and size_limit to
//   TABLE_BYTES_MAX and drops any pending result. The ring itself needs no
//   clearing: only slots of held entries are ever read.
module hpack_dynamic_table_manager #(
  parameter int ENTRY_SLOTS     = 128,
  parameter int STATIC_ENTRIES  = 61,
  parameter int TABLE_BYTES_MAX = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hdtm_pkg::hdtm_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hdtm_pkg::hdtm_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hdtm_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int PW  = $clog2(ENTRY_SLOTS);
  localparam int CW  = $clog2(ENTRY_SLOTS + 1);
  localparam int BW  = $clog2(TABLE_BYTES_MAX + 1);
  localparam int XW  = CW + 1;
  localparam int SW  = ((BW > hdtm_pkg::ESIZE_W) ? BW : hdtm_pkg::ESIZE_W) + 1;
  localparam int LW  = (BW > hdtm_pkg::LIMIT_W) ? BW : hdtm_pkg::LIMIT_W;
  localparam int RW  = ((LW > 16) ? LW : 16) + 1;

  // Ring memory of entry sizes
  logic [BW-1:0] ring [ENTRY_SLOTS];
  logic [BW-1:0] rdata;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [BW-1:0] wr_data;

  // Control state
  hdtm_pkg::hdtm_state_e state, state_next;
  logic [PW-1:0] newest, newest_next;
  logic [CW-1:0] count, count_next;
  logic [BW-1:0] bytes, bytes_next;
  logic [BW-1:0] cur_max, cur_max_next;
  logic [hdtm_pkg::LIMIT_W-1:0] size_limit, size_limit_next;
  logic          out_valid_next;

  // Item and result payload
  hdtm_pkg::hdtm_in_t     item, item_next;
  hdtm_pkg::hdtm_status_e res_status, res_status_next;
  logic [5:0]             res_spos, res_spos_next;
  logic [PW-1:0]          res_slot, res_slot_next;
  logic [CW-1:0]          evict_cnt, evict_cnt_next;
  hdtm_pkg::hdtm_out_t    out_data_next;

  // Derived values
  logic [hdtm_pkg::ESIZE_W-1:0] esize;
  logic [15:0]   idx_m1;
  logic [15:0]   dyn_idx;
  logic          static_hit;
  logic          dyn_hit;
  logic [CW-1:0] age;
  logic [XW-1:0] nx;
  logic [XW-1:0] ax;
  logic [XW-1:0] back_full;
  logic [PW-1:0] back_slot;
  logic [PW-1:0] newest_inc;
  logic [LW-1:0] limit_ext;
  logic [LW-1:0] limit_eff;
  logic          too_large;
  logic          over_fill;
  logic          ring_full;
  logic          over_req;
  logic          over_limit;
  logic [BW-1:0] bytes_less;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == hdtm_pkg::S_IDLE);

  // Entry size and lookup index split
  assign esize = hdtm_pkg::ESIZE_W'(item.name_len) + hdtm_pkg::ESIZE_W'(item.value_len)
               + hdtm_pkg::ESIZE_W'(hdtm_pkg::ENTRY_OVERHEAD);
  assign idx_m1     = item.index - 16'd1;
  assign static_hit = (item.index != 16'd0) && (idx_m1 < 16'(STATIC_ENTRIES));
  assign dyn_idx    = idx_m1 - 16'(STATIC_ENTRIES);
  assign dyn_hit    = (item.index != 16'd0) && !static_hit && (dyn_idx < 16'(count));

  // Ring slot a given age behind the newest entry
  assign age       = (item.op == hdtm_pkg::OP_LOOKUP) ? CW'(dyn_idx) : count - CW'(1);
  assign nx        = XW'(newest);
  assign ax        = XW'(age);
  assign back_full = (ax > nx) ? nx + XW'(ENTRY_SLOTS) - ax : nx - ax;
  assign back_slot = PW'(back_full);
  assign newest_inc = (newest == PW'(ENTRY_SLOTS - 1)) ? '0 : newest + PW'(1);

  // Insert and resize conditions
  assign too_large = SW'(esize) > SW'(cur_max);
  assign over_fill = (count != '0) && ((SW'(bytes) + SW'(esize)) > SW'(cur_max));
  assign ring_full = (count >= CW'(ENTRY_SLOTS));
  assign limit_ext = LW'(size_limit);
  assign limit_eff = (limit_ext > LW'(TABLE_BYTES_MAX)) ? LW'(TABLE_BYTES_MAX) : limit_ext;
  assign over_limit = RW'(item.req_size) > RW'(limit_eff);
  assign over_req  = (count != '0) && (RW'(bytes) > RW'(item.req_size));

  // Byte total after dropping the oldest entry
  assign bytes_less = (rdata > bytes) ? '0 : bytes - rdata;

  // Next state, datapath updates and memory controls
  always_comb begin
    state_next      = state;
    newest_next     = newest;
    count_next      = count;
    bytes_next      = bytes;
    cur_max_next    = cur_max;
    size_limit_next = cfg_valid ? cfg_data : size_limit;
    item_next       = item;
    res_status_next = res_status;
    res_spos_next   = res_spos;
    res_slot_next   = res_slot;
    evict_cnt_next  = evict_cnt;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    rd_en           = 1'b0;
    rd_addr         = back_slot;
    wr_en           = 1'b0;
    wr_addr         = newest_inc;
    wr_data         = BW'(esize);
    case (state)
      hdtm_pkg::S_IDLE: begin
        if (in_valid) begin
          item_next      = in_data;
          res_spos_next  = '0;
          res_slot_next  = '0;
          evict_cnt_next = '0;
          if (in_data.op == hdtm_pkg::OP_LOOKUP || in_data.op == hdtm_pkg::OP_INSERT ||
              in_data.op == hdtm_pkg::OP_RESIZE) begin
            state_next = hdtm_pkg::S_CHECK;
          end
        end
      end
      hdtm_pkg::S_CHECK: begin
        case (item.op)
          hdtm_pkg::OP_LOOKUP: begin
            if (static_hit) begin
              res_status_next = hdtm_pkg::STAT_STATIC_HIT;
              res_spos_next   = 6'(idx_m1);
            end else if (dyn_hit) begin
              res_status_next = hdtm_pkg::STAT_DYNAMIC_HIT;
              res_slot_next   = back_slot;
            end else begin
              res_status_next = hdtm_pkg::STAT_INVALID;
            end
            state_next = hdtm_pkg::S_FINISH;
          end
          hdtm_pkg::OP_INSERT: begin
            if (too_large) begin
              // Entry can never fit: empty the table
              res_status_next = hdtm_pkg::STAT_TOO_LARGE;
              evict_cnt_next  = count;
              count_next      = '0;
              bytes_next      = '0;
              state_next      = hdtm_pkg::S_FINISH;
            end else if (over_fill || ring_full) begin
              rd_en      = 1'b1;
              state_next = hdtm_pkg::S_EVICT;
            end else begin
              // Store the new entry in the next slot
              wr_en           = 1'b1;
              newest_next     = newest_inc;
              count_next      = count + CW'(1);
              bytes_next      = bytes + BW'(esize);
              res_slot_next   = newest_inc;
              res_status_next = hdtm_pkg::STAT_INSERTED;
              state_next      = hdtm_pkg::S_FINISH;
            end
          end
          hdtm_pkg::OP_RESIZE: begin
            if (over_limit) begin
              res_status_next = hdtm_pkg::STAT_OVER_LIMIT;
              state_next      = hdtm_pkg::S_FINISH;
            end else if (over_req) begin
              rd_en      = 1'b1;
              state_next = hdtm_pkg::S_EVICT;
            end else begin
              cur_max_next    = BW'(item.req_size);
              res_status_next = hdtm_pkg::STAT_RESIZED;
              state_next      = hdtm_pkg::S_FINISH;
            end
          end
          default: begin
            state_next = hdtm_pkg::S_IDLE;
          end
        endcase
      end
      hdtm_pkg::S_EVICT: begin
        // Drop the oldest entry read last cycle
        bytes_next     = bytes_less;
        count_next     = count - CW'(1);
        evict_cnt_next = evict_cnt + CW'(1);
        state_next     = hdtm_pkg::S_CHECK;
      end
      hdtm_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_data_next.status      = res_status;
          out_data_next.static_pos  = res_spos;
          out_data_next.entry_slot  = 7'(res_slot);
          out_data_next.evicted     = 8'(evict_cnt);
          out_data_next.entry_count = 8'(count);
          out_data_next.table_bytes = 13'(bytes);
          out_valid_next            = 1'b1;
          state_next                = hdtm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hdtm_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hdtm_pkg::S_IDLE;
      newest     <= '0;
      count      <= '0;
      bytes      <= '0;
      cur_max    <= BW'(TABLE_BYTES_MAX);
      size_limit <= hdtm_pkg::LIMIT_W'(TABLE_BYTES_MAX);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      newest     <= newest_next;
      count      <= count_next;
      bytes      <= bytes_next;
      cur_max    <= cur_max_next;
      size_limit <= size_limit_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item       <= item_next;
    res_status <= res_status_next;
    res_spos   <= res_spos_next;
    res_slot   <= res_slot_next;
    evict_cnt  <= evict_cnt_next;
    out_data   <= out_data_next;
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= ring[rd_addr];
    end
  end

  // Held entries never exceed the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRY_SLOTS))
    else $error("held entry count above ring depth");

  // Between operations the table fits its maximum
  a_bytes_fit: assert property (@(posedge clk) disable iff (rst)
    (state == hdtm_pkg::S_IDLE) |-> (bytes <= cur_max))
    else $error("table bytes above current maximum while idle");

  // An empty table holds no bytes
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (state == hdtm_pkg::S_IDLE && count == '0) |-> (bytes == '0))
    else $error("empty table with nonzero byte total");

  // Eviction only starts on a nonempty table
  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == hdtm_pkg::S_CHECK && state_next == hdtm_pkg::S_EVICT) |-> (count != '0))
    else $error("eviction started on an empty table");

  // Each eviction step drops exactly one entry
  a_evict_step: assert property (@(posedge clk) disable iff (rst)
    (state == hdtm_pkg::S_EVICT) |=> (count == CW'($past(count) - CW'(1))))
    else $error("eviction step did not drop one entry");

endmodule
